>>> hdl/pscm_pkg.sv
package pscm_pkg;

    localparam int PSCM_ADC_BITS = 10;
    localparam int STATUS_W      = 13;
    localparam int FW_W          = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CLASS_W       = 4;
    localparam int RATIO_W       = 10;
    localparam int CLASS_COUNT   = 15;
    localparam int SENSE_GAIN    = 510;
    localparam int GAIN_W        = $clog2(SENSE_GAIN + 1);

    localparam int BIT_DC    = 0;
    localparam int BIT_USB   = 1;
    localparam int BIT_AUX   = 5;
    localparam int BIT_ALARM = 6;
    localparam int BIT_KEY   = 11;
    localparam int BIT_JACK  = 12;

    localparam logic [FW_W-1:0] VER_KEY  = 16'h060A;
    localparam logic [FW_W-1:0] VER_JACK = 16'h060B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRMWARE = 2'd0,
        CFG_JACK_EN  = 2'd1,
        CFG_MON_EN   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KEY_NONE     = 2'd0,
        KEY_PRESSED  = 2'd1,
        KEY_RELEASED = 2'd2
    } t_key_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef logic [RATIO_W-1:0] t_ratio;

    localparam t_ratio RANGE_LO [CLASS_COUNT] = '{
        10'd43, 10'd51, 10'd62, 10'd75, 10'd91, 10'd110, 10'd135, 10'd165,
        10'd200, 10'd245, 10'd300, 10'd360, 10'd430, 10'd516, 10'd620};
    localparam t_ratio RANGE_HI [CLASS_COUNT] = '{
        10'd51, 10'd62, 10'd75, 10'd91, 10'd110, 10'd135, 10'd165, 10'd200,
        10'd245, 10'd300, 10'd360, 10'd430, 10'd515, 10'd620, 10'd750};

    // first range in table order with lo < r < hi wins
    function automatic logic [CLASS_W-1:0] ratio_class(input t_ratio r);
        logic [CLASS_W-1:0] cls;
        cls = '0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (r > RANGE_LO[i] && r < RANGE_HI[i]) begin
                cls = CLASS_W'(i + 1);
            end
        end
        return cls;
    endfunction

endpackage

>>> hdl/pscm_if.sv
interface pscm_in_if #(
    parameter int ADC_BITS = pscm_pkg::PSCM_ADC_BITS
);
    logic                          valid;
    logic                          ready;
    logic [pscm_pkg::STATUS_W-1:0] status_word;
    logic [ADC_BITS-1:0]           sense_adc;
    logic [ADC_BITS-1:0]           supply_adc;

    modport source (output valid, status_word, sense_adc, supply_adc, input ready);
    modport sink   (input valid, status_word, sense_adc, supply_adc, output ready);
endinterface

interface pscm_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   key_event;
    logic                         charge_update;
    logic                         usb_source;
    logic                         dc_source;
    logic [pscm_pkg::CLASS_W-1:0] accessory_class;
    logic                         alarm_reached;

    modport source (output valid, key_event, charge_update, usb_source, dc_source,
                    accessory_class, alarm_reached, input ready);
    modport sink   (input valid, key_event, charge_update, usb_source, dc_source,
                    accessory_class, alarm_reached, output ready);
endinterface

interface pscm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pscm_pkg::CFG_IDX_W-1:0] reg_index;
    logic [pscm_pkg::FW_W-1:0]      wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hdl/pscm_div.sv
module pscm_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_done, n_done;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_rem = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hdl/power_status_change_monitor_unit.sv
// Power status change monitor. Each input transfer carries a new power-controller
// status word and two accessory divider readings; one result transfer follows for
// every input. The block reports power-key edges (firmware 0x060a and newer), issues
// a charge-source update when the relevant source bits change, and classifies the
// accessory resistor from the ratio sense*510/(2*supply-sense). After an input
// transfer the block is not ready again until the bit-serial divider, which produces
// one quotient bit per cycle over ADC_BITS+9 bits, has finished and its result has
// been loaded into the output register. The result sits in that register, so the
// next input can be taken while it waits. Configuration writes are taken at any
// time and are expected only while the block is idle.
module power_status_change_monitor_unit #(
    parameter int ADC_BITS = pscm_pkg::PSCM_ADC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pscm_in_if.sink   i_in,
    pscm_out_if.source o_out,
    pscm_cfg_if.sink  i_cfg
);

    import pscm_pkg::*;

    localparam int NUM_W = ADC_BITS + GAIN_W;
    localparam int DEN_W = ADC_BITS + 1;

    t_state              r_state, n_state;
    logic [FW_W-1:0]     r_fw;
    logic                r_jack_en;
    logic                r_mon_en;
    logic [STATUS_W-1:0] r_prev;
    logic [STATUS_W-1:0] r_now;
    logic                r_den_ok;
    logic                r_out_valid;

    logic [1:0]          r_key;
    logic                r_upd;
    logic                r_usb;
    logic                r_dc;
    logic [CLASS_W-1:0]  r_cls;
    logic                r_alarm;

    logic                in_xfer;
    logic                div_start;
    logic                out_load;
    logic                div_done;
    logic [NUM_W-1:0]    quo;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    twice;
    logic [DEN_W-1:0]    den;
    logic                den_ok;

    t_ratio              ratio;
    logic [CLASS_W-1:0]  n_cls;
    logic [STATUS_W-1:0] diff;
    logic                legacy;
    logic [1:0]          n_key;
    logic                n_upd;
    logic                n_usb;
    logic                n_dc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= '0;
            r_jack_en <= 1'b1;
            r_mon_en  <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_FIRMWARE: r_fw      <= i_cfg.wr_data;
                CFG_JACK_EN:  r_jack_en <= i_cfg.wr_data[0];
                CFG_MON_EN:   r_mon_en  <= i_cfg.wr_data[0];
                default:      ;
            endcase
        end
    end

    // operands for the divider
    always_comb begin
        num    = NUM_W'(i_in.sense_adc) * NUM_W'(SENSE_GAIN);
        twice  = {i_in.supply_adc, 1'b0};
        den    = twice - {1'b0, i_in.sense_adc};
        den_ok = twice > {1'b0, i_in.sense_adc};
    end

    pscm_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (num),
        .i_den  (den),
        .o_done (div_done),
        .o_quo  (quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_DONE;
            ST_DONE: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_DIV:  ;
            ST_DONE: out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign in_xfer   = i_in.valid && i_in.ready;
    assign div_start = in_xfer;

    // result decision
    always_comb begin
        ratio  = (|quo[NUM_W-1:RATIO_W]) ? '1 : quo[RATIO_W-1:0];
        n_cls  = r_den_ok ? ratio_class(ratio) : '0;
        diff   = r_now ^ r_prev;
        legacy = !r_jack_en || (r_fw < VER_JACK);
        n_key  = KEY_NONE;
        n_upd  = 1'b0;
        n_usb  = 1'b0;
        n_dc   = 1'b0;
        if (r_mon_en) begin
            if (r_fw >= VER_KEY && diff[BIT_KEY]) begin
                n_key = r_now[BIT_KEY] ? KEY_PRESSED : KEY_RELEASED;
            end
            if (legacy) begin
                if (diff[BIT_AUX] || diff[BIT_USB] || diff[BIT_DC]) begin
                    n_upd = 1'b1;
                    n_usb = r_now[BIT_USB];
                    n_dc  = r_now[BIT_DC];
                end
            end else if (diff[BIT_AUX] || diff[BIT_JACK] || diff[BIT_DC]) begin
                n_upd = 1'b1;
                n_dc  = r_now[BIT_JACK] || (r_now[BIT_DC] && n_cls == CLASS_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_prev      <= r_now;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now    <= i_in.status_word;
            r_den_ok <= den_ok;
        end
        if (out_load) begin
            r_key   <= n_key;
            r_upd   <= n_upd;
            r_usb   <= n_usb;
            r_dc    <= n_dc;
            r_cls   <= n_cls;
            r_alarm <= r_now[BIT_ALARM];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.key_event       = r_key;
    assign o_out.charge_update   = r_upd;
    assign o_out.usb_source      = r_usb;
    assign o_out.dc_source       = r_dc;
    assign o_out.accessory_class = r_cls;
    assign o_out.alarm_reached   = r_alarm;

endmodule

>>> tb/power_status_change_monitor_unit_tb.sv
`timescale 1ns / 1ps

module power_status_change_monitor_unit_tb;
    import pscm_pkg::*;

    localparam int ADC_MAX       = (1 << PSCM_ADC_BITS) - 1;
    localparam int SETTLE_CYCLES = PSCM_ADC_BITS + 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] S_DC    = 13'd1 << BIT_DC;
    localparam logic [STATUS_W-1:0] S_USB   = 13'd1 << BIT_USB;
    localparam logic [STATUS_W-1:0] S_AUX   = 13'd1 << BIT_AUX;
    localparam logic [STATUS_W-1:0] S_ALARM = 13'd1 << BIT_ALARM;
    localparam logic [STATUS_W-1:0] S_KEY   = 13'd1 << BIT_KEY;
    localparam logic [STATUS_W-1:0] S_JACK  = 13'd1 << BIT_JACK;

    localparam int unsigned CLASS_LO [15] = '{
        43, 51, 62, 75, 91, 110, 135, 165, 200, 245, 300, 360, 430, 516, 620};
    localparam int unsigned CLASS_HI [15] = '{
        51, 62, 75, 91, 110, 135, 165, 200, 245, 300, 360, 430, 515, 620, 750};

    typedef struct packed {
        t_key_event           key;
        logic                 upd;
        logic                 usb;
        logic                 dc;
        logic [CLASS_W-1:0]   cls;
        logic                 alarm;
    } t_status_report;

    logic i_clk;
    logic i_rst_n;

    pscm_in_if  in_if ();
    pscm_out_if out_if ();
    pscm_cfg_if cfg_if ();

    power_status_change_monitor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_status_report    expected_reports [$];
    logic [STATUS_W-1:0] last_status;
    logic [FW_W-1:0]   fw_version;
    logic              jack_en;
    logic              mon_en;
    int                mismatch_count;
    int                src_idle_pct;
    int                sink_idle_pct;
    int                hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_status_report predict_report(input logic [STATUS_W-1:0] status,
                                                      input int unsigned sense,
                                                      input int unsigned supply);
        t_status_report rep;
        logic [STATUS_W-1:0] diff;
        int unsigned ratio;
        rep  = '0;
        diff = status ^ last_status;
        if (2 * supply > sense) begin
            ratio = (sense * 510) / (2 * supply - sense);
            for (int i = 0; i < 15; i++) begin
                if (rep.cls == 0 && ratio > CLASS_LO[i] && ratio < CLASS_HI[i]) begin
                    rep.cls = CLASS_W'(i + 1);
                end
            end
        end
        if (mon_en) begin
            if (fw_version >= VER_KEY && diff[BIT_KEY]) begin
                rep.key = status[BIT_KEY] ? KEY_PRESSED : KEY_RELEASED;
            end
            if (!jack_en || fw_version < VER_JACK) begin
                if (diff[BIT_AUX] || diff[BIT_USB] || diff[BIT_DC]) begin
                    rep.upd = 1'b1;
                    rep.usb = status[BIT_USB];
                    rep.dc  = status[BIT_DC];
                end
            end else if (diff[BIT_AUX] || diff[BIT_JACK] || diff[BIT_DC]) begin
                rep.upd = 1'b1;
                rep.dc  = status[BIT_JACK] || (status[BIT_DC] && rep.cls == 1);
            end
        end
        rep.alarm = status[BIT_ALARM];
        return rep;
    endfunction

    // receiver: random stalls, or a counted hold-off when requested
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_status_report exp_rep;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result transfer with no expectation pending");
                mismatch_count++;
            end else begin
                exp_rep = expected_reports.pop_front();
                if (out_if.key_event !== exp_rep.key) begin
                    $error("key_event: expected %0d, got %0d", exp_rep.key, out_if.key_event);
                    mismatch_count++;
                end
                if (out_if.charge_update !== exp_rep.upd) begin
                    $error("charge_update: expected %0d, got %0d", exp_rep.upd,
                           out_if.charge_update);
                    mismatch_count++;
                end
                if (out_if.usb_source !== exp_rep.usb) begin
                    $error("usb_source: expected %0d, got %0d", exp_rep.usb, out_if.usb_source);
                    mismatch_count++;
                end
                if (out_if.dc_source !== exp_rep.dc) begin
                    $error("dc_source: expected %0d, got %0d", exp_rep.dc, out_if.dc_source);
                    mismatch_count++;
                end
                if (out_if.accessory_class !== exp_rep.cls) begin
                    $error("accessory_class: expected %0d, got %0d", exp_rep.cls,
                           out_if.accessory_class);
                    mismatch_count++;
                end
                if (out_if.alarm_reached !== exp_rep.alarm) begin
                    $error("alarm_reached: expected %0d, got %0d", exp_rep.alarm,
                           out_if.alarm_reached);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_status(input logic [STATUS_W-1:0] status, input int unsigned sense,
                               input int unsigned supply);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.status_word <= status;
        in_if.sense_adc   <= PSCM_ADC_BITS'(sense);
        in_if.supply_adc  <= PSCM_ADC_BITS'(supply);
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_reports.push_back(predict_report(status, sense, supply));
        last_status = status;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FW_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_FIRMWARE: fw_version = data;
            CFG_JACK_EN:  jack_en = data[0];
            CFG_MON_EN:   mon_en = data[0];
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [FW_W-1:0] fw, input logic jack, input logic mon);
        logic [FW_W-1:0] noise;
        wait_idle();
        write_reg(CFG_FIRMWARE, fw);
        noise = FW_W'($urandom);
        write_reg(CFG_JACK_EN, {noise[FW_W-1:1], jack});
        noise = FW_W'($urandom);
        write_reg(CFG_MON_EN, {noise[FW_W-1:1], mon});
    endtask

    task automatic send_random();
        logic [STATUS_W-1:0] status;
        int unsigned sense;
        int unsigned supply;
        int unsigned target;
        int unsigned span;
        case ($urandom_range(3))
            0: status = STATUS_W'($urandom);
            1: status = last_status ^ (13'd1 << $urandom_range(STATUS_W - 1));
            2: begin
                case ($urandom_range(4))
                    0: status = last_status ^ S_DC;
                    1: status = last_status ^ S_USB;
                    2: status = last_status ^ S_AUX;
                    3: status = last_status ^ S_KEY;
                    default: status = last_status ^ S_JACK;
                endcase
            end
            default: status = last_status;
        endcase
        case ($urandom_range(4))
            0, 1: begin
                sense  = $urandom_range(ADC_MAX);
                supply = $urandom_range(ADC_MAX);
            end
            2, 3: begin
                // aim the divider ratio at a random point of the class table
                sense  = $urandom_range(1, ADC_MAX);
                target = $urandom_range(1, 800);
                span   = (sense * 510) / target;
                if (span == 0) span = 1;
                supply = (sense + span + 1) / 2;
                if (supply > ADC_MAX) supply = ADC_MAX;
            end
            default: begin
                sense  = $urandom_range(1) ? ADC_MAX - $urandom_range(1) : $urandom_range(1);
                supply = $urandom_range(1) ? ADC_MAX - $urandom_range(1) : $urandom_range(1);
            end
        endcase
        send_status(status, sense, supply);
    endtask

    task automatic test_legacy_path();
        send_status('0, 0, 0);
        send_status(S_DC, ADC_MAX, 0);
        send_status(S_DC | S_USB, 0, ADC_MAX);
        send_status(S_DC | S_USB | S_AUX, ADC_MAX, ADC_MAX);
        send_status(S_DC | S_USB | S_AUX | S_KEY, ADC_MAX, 512);
        send_status(13'h1FFF, 100, 592);
        send_status('0, 512, ADC_MAX);
    endtask

    task automatic test_key_edges();
        set_mode(VER_KEY, 1'b1, 1'b1);
        send_status(S_KEY, 300, 400);
        send_status('0, 300, 400);
        send_status(S_KEY | S_DC | S_USB, 40, 700);
        send_status(S_USB, 40, 700);
    endtask

    task automatic test_jack_path();
        set_mode(VER_JACK, 1'b1, 1'b1);
        send_status(S_JACK, 100, 592);
        send_status(S_JACK | S_DC, 100, 592);
        send_status(S_DC, 100, 592);
        send_status(S_DC | S_USB, 100, 592);
        send_status(S_DC | S_USB | S_AUX, 600, 600);
        send_status(S_KEY | S_ALARM, 0, 0);
        send_status('0, ADC_MAX, 511);
    endtask

    task automatic test_monitor_off();
        set_mode(16'hFFFF, 1'b0, 1'b0);
        send_status(S_KEY | S_DC | S_JACK, 100, 592);
        send_status(S_USB | S_AUX | S_ALARM, 900, 500);
        wait_idle();
        write_reg(CFG_UNUSED, FW_W'($urandom));
        send_status('0, 200, 300);
    endtask

    task automatic run_phase(input logic [FW_W-1:0] fw, input logic jack, input logic mon,
                             input int count);
        set_mode(fw, jack, mon);
        repeat (count) send_random();
    endtask

    task automatic test_random_traffic();
        run_phase(16'h0000, 1'b1, 1'b1, 250);
        run_phase(VER_KEY - 16'd1, 1'b0, 1'b1, 250);
        run_phase(VER_KEY, 1'b1, 1'b1, 250);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(VER_JACK, 1'b1, 1'b1, 250);
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        run_phase(16'hFFFF, 1'b1, 1'b1, 250);
        run_phase(16'hFFFF, 1'b0, 1'b0, 150);
        run_phase(FW_W'($urandom), 1'($urandom), 1'b1, 250);
    endtask

    task automatic test_backpressure();
        set_mode(VER_JACK, 1'b1, 1'b1);
        src_idle_pct = 0;
        hold_cycles  = 400;
        repeat (60) send_random();
        src_idle_pct = 25;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.status_word = '0;
        in_if.sense_adc   = '0;
        in_if.supply_adc  = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.reg_index  = CFG_FIRMWARE;
        cfg_if.wr_data    = '0;
        last_status       = '0;
        fw_version        = '0;
        jack_en           = 1'b1;
        mon_en            = 1'b1;
        mismatch_count    = 0;
        src_idle_pct      = 25;
        sink_idle_pct     = 25;
        hold_cycles       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_legacy_path();
        test_key_edges();
        test_jack_path();
        test_monitor_off();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
